[rtl/rgb565_blit_with_bit_alpha_top_defines.svh]
// assertion macros for the sprite blitter
`ifndef RGB565_BLIT_WITH_BIT_ALPHA_TOP_DEFINES_SVH
`define RGB565_BLIT_WITH_BIT_ALPHA_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RBBA_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rbba assertion failed");

// next-cycle implication, disabled while reset is low
`define RBBA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rbba assertion failed");

`endif

[rtl/rbba_pkg.sv]
package rbba_pkg;

    // frame and arithmetic sizes
    localparam int FRAME_PIXELS  = 1048576;
    localparam int ADDR_W        = $clog2(FRAME_PIXELS);
    localparam int BASE_W        = 21;
    localparam int BUF_W         = 24;
    localparam int CNT_W         = 5;
    localparam int POS_W         = 10;
    localparam int SIZE_W        = 11;
    localparam int COLOR_W       = 16;
    localparam int BYTE_TOP_BIT  = 7;
    localparam int MAX_OUT       = 8;
    localparam int MAX_IMG       = 1024;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;

    localparam logic [BASE_W-1:0]  ROW_BASE_MAX = {BASE_W{1'b1}};
    localparam logic [COLOR_W-1:0] COLOR_MASK   = 16'hFFFF;
    localparam logic [ADDR_W-1:0]  ADDR_SAT     = ADDR_W'(FRAME_PIXELS - 1);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_WIDTH   = 3'd0,
        CFG_DEST_X     = 3'd1,
        CFG_DEST_Y     = 3'd2,
        CFG_IMG_WIDTH  = 3'd3,
        CFG_IMG_HEIGHT = 3'd4,
        CFG_ALPHA_MODE = 3'd5
    } t_cfg_idx;

    // request payloads
    typedef struct packed {
        logic       first_byte;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
        logic               outside_frame;
        logic               last_pixel;
    } t_out_item;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [SIZE_W-1:0] fb_width;
        logic [POS_W-1:0]  dest_x;
        logic [POS_W-1:0]  dest_y;
        logic [SIZE_W-1:0] img_w_eff;
        logic [SIZE_W-1:0] img_h_eff;
        logic              alpha_mode;
    } t_cfg;

    // write events from the register file
    typedef struct packed {
        logic reload;
        logic stream_clr;
    } t_cfg_evt;

endpackage

[rtl/rgb565_blit_with_bit_alpha_top.sv]
// a taken request is registered into the sequencer; a first byte first passes S_LOAD,
// a base reload on the shared multiply-add; S_SCAN then takes flag bits or colour words,
// S_EMIT registers each pixel and S_ADV follows each row end; a new byte is taken only
// back in S_IDLE, and a stalled output holds the sequencer in place
// a config write forces a base reload; input is taken only when the sequencer is idle
// reset: synchronous active low; registers return to defaults, stream and position clear
`include "rgb565_blit_with_bit_alpha_top_defines.svh"

module rgb565_blit_with_bit_alpha_top
    import rbba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_SCAN = 5'b00100,
        S_EMIT = 5'b01000,
        S_ADV  = 5'b10000
    } t_state;

    localparam int N_W = $clog2(MAX_OUT + 1);

    t_cfg     cfg;
    t_cfg_evt evt;

    t_state             r_state, n_state;
    logic               r_load_ret, n_load_ret;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_flag, n_flag;
    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_row, n_row;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_opaque, n_opaque;
    logic [N_W-1:0]     r_n, n_n;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [SIZE_W-1:0]  alu_a, alu_b;
    logic [BASE_W-1:0]  alu_c, alu_sum;
    logic               col_end, row_end, outside;
    logic [BUF_W-1:0]   base_buf, ins;
    logic [CNT_W-1:0]   base_cnt;

    rbba_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_evt       (evt)
    );

    // operand select for the shared multiply-add
    always_comb begin
        case (r_state)
            S_LOAD: begin
                alu_a = SIZE_W'(cfg.dest_y) + SIZE_W'(r_row);
                alu_b = cfg.fb_width;
                alu_c = BASE_W'(cfg.dest_x);
            end
            S_ADV: begin
                alu_a = SIZE_W'(1);
                alu_b = cfg.fb_width;
                alu_c = r_base;
            end
            default: begin
                alu_a = SIZE_W'(1);
                alu_b = SIZE_W'(r_col);
                alu_c = r_base;
            end
        endcase
    end

    rbba_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_c   (alu_c),
        .o_sum (alu_sum)
    );

    // position and frame checks
    assign col_end = (SIZE_W'(r_col) + SIZE_W'(1)) >= cfg.img_w_eff;
    assign row_end = (SIZE_W'(r_row) + SIZE_W'(1)) >= cfg.img_h_eff;
    assign outside = alu_sum[ADDR_W];

    // byte insertion into the bit buffer
    assign base_buf = (r_cnt > CNT_W'(15)) ? '0 : r_buf;
    assign base_cnt = (r_cnt > CNT_W'(15)) ? '0 : r_cnt;
    assign ins      = BUF_W'(i_in_data.data_byte) << base_cnt;

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_load_ret  = r_load_ret;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_flag      = r_flag;
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_color     = r_color;
        n_opaque    = r_opaque;
        n_n         = r_n;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (evt.reload) begin
            if (evt.stream_clr) begin
                n_buf  = '0;
                n_cnt  = '0;
                n_flag = 1'b0;
            end
            n_load_ret = 1'b0;
            n_state    = S_LOAD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        n_n = '0;
                        if (i_in_data.first_byte) begin
                            n_buf      = BUF_W'(i_in_data.data_byte);
                            n_cnt      = CNT_W'(BYTE_TOP_BIT + 1);
                            n_flag     = 1'b0;
                            n_col      = '0;
                            n_row      = '0;
                            n_load_ret = 1'b1;
                            n_state    = S_LOAD;
                        end else begin
                            n_buf   = base_buf | ins;
                            n_cnt   = base_cnt + CNT_W'(BYTE_TOP_BIT + 1);
                            n_flag  = (r_cnt > CNT_W'(15)) ? 1'b0 : r_flag;
                            n_state = S_SCAN;
                        end
                    end
                end
                // base reload from the current row
                S_LOAD: begin
                    n_base  = alu_sum;
                    n_state = r_load_ret ? S_SCAN : S_IDLE;
                end
                // take a flag bit or a colour word from the buffer
                S_SCAN: begin
                    if (r_n == N_W'(MAX_OUT)) begin
                        n_state = S_IDLE;
                    end else if (cfg.alpha_mode && !r_flag) begin
                        if (r_cnt == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_buf = r_buf >> 1;
                            n_cnt = r_cnt - CNT_W'(1);
                            if (r_buf[0]) begin
                                n_flag = 1'b1;
                            end else begin
                                n_color  = '0;
                                n_opaque = 1'b0;
                                n_state  = S_EMIT;
                            end
                        end
                    end else begin
                        if (r_cnt < CNT_W'(COLOR_W)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_color  = r_buf[COLOR_W-1:0] & COLOR_MASK;
                            n_buf    = r_buf >> COLOR_W;
                            n_cnt    = r_cnt - CNT_W'(COLOR_W);
                            n_flag   = 1'b0;
                            n_opaque = 1'b1;
                            n_state  = S_EMIT;
                        end
                    end
                end
                // address and result register, then step the position
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        n_out.pixel_address = outside ? ADDR_SAT : alu_sum[ADDR_W-1:0];
                        n_out.pixel_color   = r_color;
                        n_out.write_enable  = r_opaque && !outside;
                        n_out.outside_frame = outside;
                        n_out.last_pixel    = col_end && row_end;
                        n_out_valid         = 1'b1;
                        n_n                 = r_n + N_W'(1);
                        if (col_end && row_end) begin
                            n_buf      = '0;
                            n_cnt      = '0;
                            n_flag     = 1'b0;
                            n_col      = '0;
                            n_row      = '0;
                            n_load_ret = 1'b0;
                            n_state    = S_LOAD;
                        end else if (col_end) begin
                            n_col   = '0;
                            n_row   = r_row + POS_W'(1);
                            n_state = S_ADV;
                        end else begin
                            n_col   = r_col + POS_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                end
                // next row base
                S_ADV: begin
                    n_base  = alu_sum;
                    n_state = S_SCAN;
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_ret  <= 1'b0;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_flag      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_base      <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_ret  <= n_load_ret;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_flag      <= n_flag;
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_color  <= n_color;
        r_opaque <= n_opaque;
        r_out    <= n_out;
    end

    // checks
    `RBBA_ASSERT_NOW(a_we_inside, i_clk, i_rst_n, o_out_valid && o_out_data.write_enable, !o_out_data.outside_frame)
    `RBBA_ASSERT_NOW(a_sat_addr, i_clk, i_rst_n, o_out_valid && o_out_data.outside_frame, o_out_data.pixel_address == ADDR_SAT)
    `RBBA_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(23))
    `RBBA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

[rtl/rbba_alu.sv]
module rbba_alu
    import rbba_pkg::*;
(
    input  logic [SIZE_W-1:0] i_a,
    input  logic [SIZE_W-1:0] i_b,
    input  logic [BASE_W-1:0] i_c,
    output logic [BASE_W-1:0] o_sum
);

    localparam int PROD_W = 2 * SIZE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    // shared multiply-add, saturated to the row base range
    assign prod  = PROD_W'(i_a) * PROD_W'(i_b);
    assign sum   = SUM_W'(prod) + SUM_W'(i_c);
    assign o_sum = (sum[SUM_W-1:BASE_W] != '0) ? ROW_BASE_MAX : sum[BASE_W-1:0];

endmodule

[rtl/rbba_cfg.sv]
module rbba_cfg
    import rbba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_cfg_evt              o_evt
);

    logic [SIZE_W-1:0] r_fb_width;
    logic [POS_W-1:0]  r_dest_x;
    logic [POS_W-1:0]  r_dest_y;
    logic [SIZE_W-1:0] r_img_w;
    logic [SIZE_W-1:0] r_img_h;
    logic              r_alpha;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width <= SIZE_W'(320);
            r_dest_x   <= '0;
            r_dest_y   <= '0;
            r_img_w    <= SIZE_W'(1);
            r_img_h    <= SIZE_W'(1);
            r_alpha    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FB_WIDTH:   r_fb_width <= i_cfg_data[SIZE_W-1:0];
                CFG_DEST_X:     r_dest_x   <= i_cfg_data[POS_W-1:0];
                CFG_DEST_Y:     r_dest_y   <= i_cfg_data[POS_W-1:0];
                CFG_IMG_WIDTH:  r_img_w    <= i_cfg_data[SIZE_W-1:0];
                CFG_IMG_HEIGHT: r_img_h    <= i_cfg_data[SIZE_W-1:0];
                CFG_ALPHA_MODE: r_alpha    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // write events: any known index reloads the base, mode write clears the stream
    always_comb begin
        o_evt = '0;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FB_WIDTH, CFG_DEST_X, CFG_DEST_Y,
                CFG_IMG_WIDTH, CFG_IMG_HEIGHT: o_evt.reload = 1'b1;
                CFG_ALPHA_MODE: begin
                    o_evt.reload     = 1'b1;
                    o_evt.stream_clr = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // zero size acts as one, oversize as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_IMG)) r = SIZE_W'(MAX_IMG);
        return r;
    endfunction

    always_comb begin
        o_cfg.fb_width   = r_fb_width;
        o_cfg.dest_x     = r_dest_x;
        o_cfg.dest_y     = r_dest_y;
        o_cfg.img_w_eff  = clamp_size(r_img_w);
        o_cfg.img_h_eff  = clamp_size(r_img_h);
        o_cfg.alpha_mode = r_alpha;
    end

endmodule
